### rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, round constants and helper functions for the SHA-256 block.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

  // input beat: one optional message byte and an end marker
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_beat_t;

  // output beat: one digest word
  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } out_beat_t;

  // one 512-bit block handed from the front to the compression engine
  typedef struct packed {
    logic [15:0][31:0] words;  // words[0] is the first word of the block
    logic              last;   // final block of a message
  } job_t;

  localparam int unsigned RoundCount = 64;
  localparam int unsigned LengthPos  = 56;
  localparam logic [7:0]  PadByte    = 8'h80;

  localparam logic [31:0] RoundK [RoundCount] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage

`default_nettype wire

### rtl/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front
// Takes input beats, gathers bytes into a block, counts the message length
// and issues full, padded and length blocks to the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  output logic                 full,
  input  wire sha_pkg::in_beat_t in_data_i,
  output logic                 job_push_o,
  output sha_pkg::job_t        job_o,
  input  wire logic            job_full_i
);
  import sha_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_FULL = 4'b0010,
    F_PAD1 = 4'b0100,
    F_PAD2 = 4'b1000
  } front_state_e;

  front_state_e      state_q, state_d;
  logic [31:0]       words_q [16];
  logic [63:0]       len_q, len_d;
  logic              end_q, end_d;
  logic [5:0]        fill;
  logic              accept;
  logic [15:0][31:0] pad_words;

  assign fill   = len_q[8:3];
  assign accept = push && !full;
  assign full   = (state_q != F_IDLE);

  // byte gather, no reset on payload
  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.byte_valid) begin
      words_q[fill[5:2]][8*(3 - fill[1:0]) +: 8] <= in_data_i.data_byte;
    end
  end

  // first padding block: kept bytes, pad marker, zeros and maybe the length
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      for (int b = 0; b < 4; b++) begin
        if (6'(4*i + b) < fill) begin
          pad_words[i][8*(3-b) +: 8] = words_q[i][8*(3-b) +: 8];
        end else if (6'(4*i + b) == fill) begin
          pad_words[i][8*(3-b) +: 8] = PadByte;
        end else begin
          pad_words[i][8*(3-b) +: 8] = 8'h00;
        end
      end
    end
    if (fill < 6'(LengthPos)) begin
      pad_words[14] = len_q[63:32];
      pad_words[15] = len_q[31:0];
    end
  end

  // job issue and sequencing
  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    end_d      = end_q;
    job_push_o = 1'b0;
    job_o      = '0;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          end_d = in_data_i.end_of_message;
          if (in_data_i.byte_valid) begin
            len_d = len_q + 64'd8;
          end
          if (in_data_i.byte_valid && (fill == 6'd63)) begin
            state_d = F_FULL;
          end else if (in_data_i.end_of_message) begin
            state_d = F_PAD1;
          end
        end
      end
      F_FULL: begin
        for (int i = 0; i < 16; i++) job_o.words[i] = words_q[i];
        job_o.last = 1'b0;
        if (!job_full_i) begin
          job_push_o = 1'b1;
          state_d    = end_q ? F_PAD1 : F_IDLE;
        end
      end
      F_PAD1: begin
        job_o.words = pad_words;
        job_o.last  = (fill < 6'(LengthPos));
        if (!job_full_i) begin
          job_push_o = 1'b1;
          if (fill < 6'(LengthPos)) begin
            state_d = F_IDLE;
            len_d   = '0;
          end else begin
            state_d = F_PAD2;
          end
        end
      end
      F_PAD2: begin
        job_o.words[14] = len_q[63:32];
        job_o.words[15] = len_q[31:0];
        job_o.last      = 1'b1;
        if (!job_full_i) begin
          job_push_o = 1'b1;
          state_d    = F_IDLE;
          len_d      = '0;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      len_q   <= '0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      end_q   <= end_d;
    end
  end

  // a full block is only issued when the fill wrapped to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_FULL) |-> (fill == 6'd0))
    else $error("full block issued with nonzero fill");
  // the length block follows a padding block that had no room for the length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_PAD2) |-> (len_q[8:3] >= 6'(LengthPos)))
    else $error("length block without overflowing pad");

endmodule

`default_nettype wire

### rtl/sha_jobq.sv
// ----------------------------------------------------------------------------
// sha_jobq
// Two-entry queue of blocks between the front and the compression engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_jobq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire sha_pkg::job_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output sha_pkg::job_t      data_o,
  output logic               empty_o
);
  import sha_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wr_q <= ~wr_q;
      if (pop_i && !empty_o) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && !empty_o);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("job queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wr_q != rd_q))
    else $error("job queue pointers disagree with count");

endmodule

`default_nettype wire

### rtl/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core
// Compression engine: one round per cycle with a rolling message schedule,
// hash update, and digest word output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sha_pkg::job_t    job_i,
  input  wire logic             job_empty_i,
  output logic                  job_pop_o,
  output logic                  empty,
  input  wire logic             pop,
  output sha_pkg::out_beat_t    out_data_o
);
  import sha_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_ROUND = 4'b0010,
    B_ADD   = 4'b0100,
    B_EMIT  = 4'b1000
  } core_state_e;

  core_state_e state_q;
  logic [31:0] hash_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [5:0]  rnd_q;
  logic        last_q;
  logic [2:0]  idx_q;
  logic        out_valid_q, out_last_q;
  logic [31:0] out_word_q;
  logic [31:0] t1, t2, w_new;
  logic        load;

  assign empty                  = !out_valid_q;
  assign out_data_o.digest_word = out_word_q;
  assign out_data_o.digest_last = out_last_q;
  assign job_pop_o              = (state_q == B_IDLE) && !job_empty_i;
  assign load = (state_q == B_EMIT) && (!out_valid_q || pop);

  // round datapath
  always_comb begin
    t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + RoundK[rnd_q] + w_q[0];
    t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    w_new = w_q[0] + sig0(w_q[1]) + w_q[9] + sig1(w_q[14]);
  end

  // working variables and schedule, no reset on payload
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      for (int i = 0; i < 16; i++) w_q[i] <= job_i.words[i];
      for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
      last_q <= job_i.last;
    end else if (state_q == B_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
    if (load) begin
      out_word_q <= hash_q[idx_q];
    end
  end

  // control, hash words and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      rnd_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      for (int i = 0; i < 8; i++) hash_q[i] <= InitHash[i];
    end else begin
      if (pop && out_valid_q && !load) out_valid_q <= 1'b0;
      case (state_q)
        B_IDLE: begin
          if (job_pop_o) begin
            rnd_q   <= '0;
            state_q <= B_ROUND;
          end
        end
        B_ROUND: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) state_q <= B_ADD;
        end
        B_ADD: begin
          for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
          idx_q   <= '0;
          state_q <= last_q ? B_EMIT : B_IDLE;
        end
        B_EMIT: begin
          if (load) begin
            out_valid_q <= 1'b1;
            out_last_q  <= (idx_q == 3'd7);
            idx_q       <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) hash_q[i] <= InitHash[i];
              state_q <= B_IDLE;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // the final digest word hands the engine back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && idx_q == 3'd7) |=> (state_q == B_IDLE && out_last_q))
    else $error("digest did not finish after eighth word");
  // the schedule leaves the round state exactly after the last round
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_ADD) |-> (rnd_q == 6'd0))
    else $error("hash update before all rounds done");

endmodule

`default_nettype wire

### rtl/sha256_message_digest.sv
// ----------------------------------------------------------------------------
// sha256_message_digest
// SHA-256 digest of a byte stream, emitted as eight 32-bit words.
// ----------------------------------------------------------------------------
// A beat carries at most one message byte and may end the message. Bytes are
// taken one per cycle while a block fills; a beat that completes a 64-byte
// block or ends the message holds off input while its full, padding and, if
// needed, length blocks are issued. Blocks go through a two-entry queue to a
// compression engine that runs one round per cycle; each block is loaded, run
// through 64 rounds and added into the hash. Once the queue is full, input
// stalls until the engine catches up. After the last block the eight digest
// words come out most significant first, the last one marked, and the hash
// returns to its initial values for the next message.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_message_digest (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire sha_pkg::in_beat_t  in_data_i,
  output logic                    empty,
  input  wire logic               pop,
  output sha_pkg::out_beat_t      out_data_o
);
  import sha_pkg::*;

  job_t front_job, core_job;
  logic front_push, q_full, q_empty, core_pop;

  sha_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .job_push_o (front_push),
    .job_o      (front_job),
    .job_full_i (q_full)
  );

  sha_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_job),
    .full_o  (q_full),
    .pop_i   (core_pop),
    .data_o  (core_job),
    .empty_o (q_empty)
  );

  sha_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (core_job),
    .job_empty_i (q_empty),
    .job_pop_o   (core_pop),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
